### rtl/core/lozd_pkg.sv
// Package for the low-side z-score outlier detector.
// Holds widths, reset values, level codes, opcodes, states and the shared structs.
// No dependencies.
package lozd_pkg;

    localparam int COUNT_BITS_DEF  = 24;
    localparam int SAMPLE_BITS_DEF = 16;

    // Widths of the shared iterative unit and of the statistics.
    localparam int OPA_W    = 48;
    localparam int OPB_W    = 32;
    localparam int MEAN_W   = 32;
    localparam int SS_W     = 48;
    localparam int SHIFT_W  = 40;
    localparam int STEP_W   = 6;
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 48;

    localparam int CFG_W    = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [CFG_W-1:0] DEF_REQUIRED = 16'd100;
    localparam logic [CFG_W-1:0] DEF_INFO     = 16'd512;
    localparam logic [CFG_W-1:0] DEF_WARNING  = 16'd768;
    localparam logic [CFG_W-1:0] DEF_CRITICAL = 16'd1024;
    localparam logic [CFG_W-1:0] MIN_REQUIRED = 16'd2;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_REQUIRED = 2'd0;
    localparam logic [1:0] REG_INFO     = 2'd1;
    localparam logic [1:0] REG_WARNING  = 2'd2;
    localparam logic [1:0] REG_CRITICAL = 2'd3;

    // Severity codes.
    localparam logic [2:0] LVL_LEARN    = 3'd0;
    localparam logic [2:0] LVL_NOMINAL  = 3'd1;
    localparam logic [2:0] LVL_INFO     = 3'd2;
    localparam logic [2:0] LVL_WARNING  = 3'd3;
    localparam logic [2:0] LVL_CRITICAL = 3'd4;

    // Threshold walk order.
    localparam logic [1:0] THR_INFO     = 2'd0;
    localparam logic [1:0] THR_WARNING  = 2'd1;
    localparam logic [1:0] THR_CRITICAL = 2'd2;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MSQ_GO,
        ST_MSQ_W,
        ST_SCL_GO,
        ST_SCL_W,
        ST_VAR,
        ST_D2_GO,
        ST_D2_W,
        ST_THR_GO,
        ST_THR_W,
        ST_POST,
        ST_LSQ_GO,
        ST_LSQ_W,
        ST_LUPD,
        ST_LMEAN_W,
        ST_LSS_GO,
        ST_LSS_W,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] required;
        logic [CFG_W-1:0] info;
        logic [CFG_W-1:0] warning;
        logic [CFG_W-1:0] critical;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  level;
        logic [31:0] rtime;
    } res_t;

endpackage

### rtl/core/lozd_iter.sv
// Shared iterative arithmetic unit: shift-add multiply and restoring divide,
// one bit per cycle on a single 49-bit adder. Depends on lozd_pkg.
module lozd_iter (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  lozd_pkg::op_t            op,
    input  logic [lozd_pkg::OPA_W-1:0] opa,
    input  logic [lozd_pkg::OPB_W-1:0] opb,
    output logic                     done,
    output logic [lozd_pkg::OPA_W-1:0] res_hi,
    output logic [lozd_pkg::OPB_W-1:0] res_lo
);
    import lozd_pkg::*;

    op_t               op_reg, op_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [OPA_W-1:0]  hi_reg, hi_next;
    logic [OPB_W-1:0]  lo_reg, lo_next;
    logic [OPA_W-1:0]  opnd_reg, opnd_next;
    logic [OPA_W:0]    add_x, add_y, sum;
    logic              cin, qbit;

    // For a multiply hi:lo is the partial product; for a divide hi holds the
    // dividend turning into the quotient and lo the partial remainder.
    always_comb begin
        if (op_reg == OP_MUL) begin
            add_x = {1'b0, hi_reg};
            add_y = lo_reg[0] ? {1'b0, opnd_reg} : '0;
            cin   = 1'b0;
        end else begin
            add_x = {16'b0, lo_reg, hi_reg[OPA_W-1]};
            add_y = ~{1'b0, opnd_reg};
            cin   = 1'b1;
        end
        sum  = add_x + add_y + (OPA_W+1)'(cin);
        qbit = ~sum[OPA_W];
    end

    always_comb begin
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        opnd_next = opnd_reg;
        if (start) begin
            op_next   = op;
            busy_next = 1'b1;
            if (op == OP_MUL) begin
                cnt_next  = STEP_W'(MUL_STEPS - 1);
                hi_next   = '0;
                lo_next   = opb;
                opnd_next = opa;
            end else begin
                cnt_next  = STEP_W'(DIV_STEPS - 1);
                hi_next   = opa;
                lo_next   = '0;
                opnd_next = OPA_W'(opb);
            end
        end else if (busy_reg) begin
            if (op_reg == OP_MUL) begin
                hi_next = sum[OPA_W:1];
                lo_next = {sum[0], lo_reg[OPB_W-1:1]};
            end else begin
                hi_next = {hi_reg[OPA_W-2:0], qbit};
                lo_next = qbit ? sum[OPB_W-1:0] : add_x[OPB_W-1:0];
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        opnd_reg <= opnd_next;
    end

    assign done   = done_reg;
    assign res_hi = hi_reg;
    assign res_lo = lo_reg;

endmodule

### rtl/core/lozd_ctrl.sv
// Sequencer and statistics registers of the detector: learns samples and
// scores them through the shared unit. Depends on lozd_pkg and lozd_iter.
module lozd_ctrl #(
    parameter int COUNT_BITS  = lozd_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = lozd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lozd_pkg::cfg_t         cfg,
    input  logic                   in_valid,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic [31:0]            in_time,
    input  logic                   out_free,
    output logic                   idle,
    output logic                   res_valid,
    output lozd_pkg::res_t         res
);
    import lozd_pkg::*;

    state_t                 state_reg, state_next;
    logic [MEAN_W-1:0]      mean_reg, mean_next;
    logic [SS_W-1:0]        ss_reg, ss_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [COUNT_BITS-1:0]  n_reg, n_next;
    logic [SAMPLE_BITS-1:0] samp_reg, samp_next;
    logic [31:0]            time_reg, time_next;
    logic [31:0]            rtime_reg, rtime_next;
    logic [2:0]             level_reg, level_next;
    logic [SS_W-1:0]        msq_reg, msq_next;
    logic [SS_W+1:0]        var_reg, var_next;
    logic [31:0]            d_reg, d_next;
    logic [63:0]            d2_reg, d2_next;
    logic [SS_W-1:0]        sin_reg, sin_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   neg_reg, neg_next;

    logic                   u_start, u_done;
    op_t                    u_op;
    logic [OPA_W-1:0]       u_opa, u_hi;
    logic [OPB_W-1:0]       u_opb, u_lo;

    logic [CFG_W-1:0]       need;
    logic                   scoring;
    logic [COUNT_BITS-1:0]  n_inc;
    logic [15:0]            thr;
    logic [31:0]            t2;
    logic [79:0]            prod;
    logic [SHIFT_W-1:0]     s40;
    logic [MEAN_W-1:0]      m_in;
    logic [SHIFT_W:0]       d41;
    logic                   var_pos;
    logic [MEAN_W:0]        mdiff, mmag, msum;
    logic [SS_W:0]          sdiff, smag, ssum;
    logic [OPA_W-1:0]       qadj;

    lozd_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (u_start),
        .op      (u_op),
        .opa     (u_opa),
        .opb     (u_opb),
        .done    (u_done),
        .res_hi  (u_hi),
        .res_lo  (u_lo)
    );

    always_comb begin
        need    = (cfg.required < MIN_REQUIRED) ? MIN_REQUIRED : cfg.required;
        scoring = count_reg >= COUNT_BITS'(need);
        n_inc   = (&count_reg) ? count_reg : count_reg + 1'b1;
        case (idx_reg)
            THR_INFO:    thr = cfg.info;
            THR_WARNING: thr = cfg.warning;
            default:     thr = cfg.critical;
        endcase
        t2      = thr * thr;
        prod    = {u_hi, u_lo};
        s40     = SHIFT_W'(samp_reg) << 16;
        m_in    = (|s40[SHIFT_W-1:MEAN_W]) ? '1 : s40[MEAN_W-1:0];
        d41     = {9'b0, mean_reg} - {1'b0, s40};
        var_pos = ~var_reg[SS_W+1] && (var_reg != '0);
        mdiff   = {1'b0, m_in} - {1'b0, mean_reg};
        mmag    = mdiff[MEAN_W] ? ('0 - mdiff) : mdiff;
        msum    = {1'b0, mean_reg} + {1'b0, m_in};
        sdiff   = {1'b0, sin_reg} - {1'b0, ss_reg};
        smag    = sdiff[SS_W] ? ('0 - sdiff) : sdiff;
        ssum    = {1'b0, ss_reg} + {1'b0, sin_reg};
        // Floor division of a negative difference rounds the magnitude up.
        qadj    = u_hi + OPA_W'(neg_reg && (u_lo != '0));
    end

    always_comb begin
        state_next = state_reg;
        mean_next  = mean_reg;
        ss_next    = ss_reg;
        count_next = count_reg;
        n_next     = n_reg;
        samp_next  = samp_reg;
        time_next  = time_reg;
        rtime_next = rtime_reg;
        level_next = level_reg;
        msq_next   = msq_reg;
        var_next   = var_reg;
        d_next     = d_reg;
        d2_next    = d2_reg;
        sin_next   = sin_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        u_start    = 1'b0;
        u_op       = OP_MUL;
        u_opa      = '0;
        u_opb      = '0;
        res_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    samp_next  = in_sample;
                    time_next  = in_time;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (scoring) begin
                    rtime_next = time_reg;
                    state_next = ST_MSQ_GO;
                end else begin
                    rtime_next = '0;
                    level_next = LVL_LEARN;
                    state_next = ST_LSQ_GO;
                end
            end
            ST_MSQ_GO: begin
                u_start    = 1'b1;
                u_op       = OP_MUL;
                u_opa      = OPA_W'(mean_reg);
                u_opb      = mean_reg;
                state_next = ST_MSQ_W;
            end
            ST_MSQ_W: begin
                if (u_done) begin
                    msq_next   = prod[63:16];
                    state_next = ST_SCL_GO;
                end
            end
            ST_SCL_GO: begin
                u_start    = 1'b1;
                u_op       = OP_DIV;
                u_opa      = msq_reg;
                u_opb      = OPB_W'(count_reg - 1'b1);
                state_next = ST_SCL_W;
            end
            ST_SCL_W: begin
                if (u_done) begin
                    var_next   = {2'b0, ss_reg} - ({2'b0, msq_reg} + (SS_W+2)'(u_hi));
                    state_next = ST_VAR;
                end
            end
            ST_VAR: begin
                if (!var_pos) begin
                    level_next = (!d41[SHIFT_W] && d41 != '0) ? LVL_CRITICAL : LVL_NOMINAL;
                    state_next = ST_POST;
                end else if (d41[SHIFT_W]) begin
                    level_next = LVL_NOMINAL;
                    state_next = ST_POST;
                end else begin
                    d_next     = d41[31:0];
                    state_next = ST_D2_GO;
                end
            end
            ST_D2_GO: begin
                u_start    = 1'b1;
                u_op       = OP_MUL;
                u_opa      = OPA_W'(d_reg);
                u_opb      = d_reg;
                state_next = ST_D2_W;
            end
            ST_D2_W: begin
                if (u_done) begin
                    d2_next    = prod[63:0];
                    idx_next   = THR_INFO;
                    state_next = ST_THR_GO;
                end
            end
            ST_THR_GO: begin
                // A zero threshold is always met.
                if (thr == '0) begin
                    if (idx_reg == THR_CRITICAL) begin
                        level_next = LVL_CRITICAL;
                        state_next = ST_POST;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    u_start    = 1'b1;
                    u_op       = OP_MUL;
                    u_opa      = var_reg[SS_W-1:0];
                    u_opb      = t2;
                    state_next = ST_THR_W;
                end
            end
            ST_THR_W: begin
                if (u_done) begin
                    if ({16'b0, d2_reg} < prod) begin
                        case (idx_reg)
                            THR_INFO:    level_next = LVL_NOMINAL;
                            THR_WARNING: level_next = LVL_INFO;
                            default:     level_next = LVL_WARNING;
                        endcase
                        state_next = ST_POST;
                    end else if (idx_reg == THR_CRITICAL) begin
                        level_next = LVL_CRITICAL;
                        state_next = ST_POST;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_THR_GO;
                    end
                end
            end
            ST_POST: begin
                if (level_reg == LVL_NOMINAL || level_reg == LVL_INFO) begin
                    state_next = ST_LSQ_GO;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_LSQ_GO: begin
                u_start    = 1'b1;
                u_op       = OP_MUL;
                u_opa      = OPA_W'(samp_reg);
                u_opb      = OPB_W'(samp_reg);
                state_next = ST_LSQ_W;
            end
            ST_LSQ_W: begin
                if (u_done) begin
                    sin_next   = (|prod[47:32]) ? '1 : {prod[31:0], 16'b0};
                    n_next     = n_inc;
                    count_next = n_inc;
                    state_next = ST_LUPD;
                end
            end
            ST_LUPD: begin
                if (n_reg == COUNT_BITS'(1)) begin
                    mean_next  = m_in;
                    ss_next    = sin_reg;
                    state_next = ST_FINISH;
                end else if (n_reg == COUNT_BITS'(2)) begin
                    mean_next  = msum[MEAN_W:1];
                    ss_next    = ssum[SS_W] ? '1 : ssum[SS_W-1:0];
                    state_next = ST_FINISH;
                end else begin
                    neg_next   = mdiff[MEAN_W];
                    u_start    = 1'b1;
                    u_op       = OP_DIV;
                    u_opa      = OPA_W'(mmag[MEAN_W-1:0]);
                    u_opb      = OPB_W'(n_reg);
                    state_next = ST_LMEAN_W;
                end
            end
            ST_LMEAN_W: begin
                if (u_done) begin
                    mean_next  = neg_reg ? mean_reg - qadj[MEAN_W-1:0]
                                         : mean_reg + qadj[MEAN_W-1:0];
                    state_next = ST_LSS_GO;
                end
            end
            ST_LSS_GO: begin
                neg_next   = sdiff[SS_W];
                u_start    = 1'b1;
                u_op       = OP_DIV;
                u_opa      = smag[SS_W-1:0];
                u_opb      = OPB_W'(n_reg - 1'b1);
                state_next = ST_LSS_W;
            end
            ST_LSS_W: begin
                if (u_done) begin
                    ss_next    = neg_reg ? ss_reg - qadj : ss_reg + qadj;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mean_reg  <= '0;
            ss_reg    <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            mean_reg  <= mean_next;
            ss_reg    <= ss_next;
            count_reg <= count_next;
        end
        n_reg     <= n_next;
        samp_reg  <= samp_next;
        time_reg  <= time_next;
        rtime_reg <= rtime_next;
        level_reg <= level_next;
        msq_reg   <= msq_next;
        var_reg   <= var_next;
        d_reg     <= d_next;
        d2_reg    <= d2_next;
        sin_reg   <= sin_next;
        idx_reg   <= idx_next;
        neg_reg   <= neg_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res.level = level_reg;
    assign res.rtime = rtime_reg;

endmodule

### rtl/core/low_outlier_zscore_detector_core.sv
// One request is in work at a time; the next can be taken once the result is in the output
// register. The shared 49-bit adder runs one bit per cycle. Reset (aresetn, synchronous,
// active low) zeroes the statistics and loads the register defaults 100, 512, 768 and 1024.
module low_outlier_zscore_detector_core #(
    parameter int COUNT_BITS  = lozd_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = lozd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [47:0]                  s_tdata,  // sample_value[15:0], sample_time[47:16]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,  // severity_level[2:0], result_time[34:3]
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lozd_pkg::ADDR_W-1:0]  paddr,
    input  logic [lozd_pkg::DATA_W-1:0]  pwdata,
    output logic [lozd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import lozd_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       mvalid_reg, mvalid_next;
    res_t       out_reg, out_next;
    logic       idle, res_valid, out_free, wr_en;
    res_t       res;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_REQUIRED: cfg_next.required = pwdata[CFG_W-1:0];
                REG_INFO:     cfg_next.info     = pwdata[CFG_W-1:0];
                REG_WARNING:  cfg_next.warning  = pwdata[CFG_W-1:0];
                REG_CRITICAL: cfg_next.critical = pwdata[CFG_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
        case (reg_idx)
            REG_REQUIRED: prdata = DATA_W'(cfg_reg.required);
            REG_INFO:     prdata = DATA_W'(cfg_reg.info);
            REG_WARNING:  prdata = DATA_W'(cfg_reg.warning);
            REG_CRITICAL: prdata = DATA_W'(cfg_reg.critical);
            default:      prdata = '0;
        endcase
    end

    // The output register lets a finished result wait while a new request is taken.
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        mvalid_next = mvalid_reg;
        out_next    = out_reg;
        if (res_valid) begin
            mvalid_next = 1'b1;
            out_next    = res;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg    <= '{required: DEF_REQUIRED, info: DEF_INFO,
                            warning: DEF_WARNING, critical: DEF_CRITICAL};
            mvalid_reg <= 1'b0;
        end else begin
            cfg_reg    <= cfg_next;
            mvalid_reg <= mvalid_next;
        end
        out_reg <= out_next;
    end

    lozd_ctrl #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid && s_tready),
        .in_sample (SAMPLE_BITS'(s_tdata[15:0])),
        .in_time   (s_tdata[47:16]),
        .out_free  (out_free),
        .idle      (idle),
        .res_valid (res_valid),
        .res       (res)
    );

    assign s_tready = idle;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {5'b0, out_reg.rtime, out_reg.level};

endmodule

### rtl/core/lozd_chk.sv
// Port-level checker for the detector, bound to the top level.
// Depends on lozd_pkg and low_outlier_zscore_detector_core.
module lozd_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [39:0]                  m_tdata
);
    import lozd_pkg::*;

    // A result left waiting holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one request is in work at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // Learning results carry a zero timestamp.
    a_learn_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == LVL_LEARN |-> m_tdata[34:3] == '0)
        else $error("learning result with nonzero time");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= LVL_CRITICAL && m_tdata[39:35] == '0)
        else $error("bad severity or pad bits");

endmodule

bind low_outlier_zscore_detector_core lozd_chk u_lozd_chk (.*);

### bench/low_outlier_zscore_detector_core_test.sv
// Self-checking testbench for the low-side z-score outlier detector core.
// Drives samples over the stream input, the registers over APB, and checks every
// result against a predictor kept here. Depends on lozd_pkg and the core only.
`timescale 1ns / 100ps

module low_outlier_zscore_detector_core_test;

    import lozd_pkg::*;

    localparam longint unsigned STORE_MAX = (64'd1 << 48) - 1;
    localparam longint unsigned COUNT_MAX = (64'd1 << 24) - 1;
    localparam int TIMEOUT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // sample_value[15:0], sample_time[47:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // severity_level[2:0], result_time[34:3]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    low_outlier_zscore_detector_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor copy of the detector's registers and statistics.
    longint unsigned need_count, info_lvl, warn_lvl, crit_lvl;
    longint unsigned mean_fx, sumsq_fx, seen_count;

    res_t severity_queue[$];
    int   error_count = 0;
    int   sent_count = 0;
    int   result_count = 0;
    int   level_hits[5];
    int   cycle_count = 0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_requests = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if (a % d != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic void learn_sample(longint unsigned s);
        longint unsigned n, m_in, sq, s_in;
        n = (seen_count < COUNT_MAX) ? seen_count + 1 : COUNT_MAX;
        m_in = s << 16;
        sq = s * s;
        s_in = (sq > (STORE_MAX >> 16)) ? STORE_MAX : (sq << 16);
        if (m_in > 64'hFFFF_FFFF)
            m_in = 64'hFFFF_FFFF;
        seen_count = n;
        if (n == 1) begin
            mean_fx = m_in;
            sumsq_fx = s_in;
        end else if (n == 2) begin
            mean_fx = (mean_fx + m_in) >> 1;
            sumsq_fx = sumsq_fx + s_in;
            if (sumsq_fx > STORE_MAX)
                sumsq_fx = STORE_MAX;
        end else begin
            mean_fx = longint'(mean_fx) + floor_div(longint'(m_in) - longint'(mean_fx),
                                                    longint'(n));
            sumsq_fx = longint'(sumsq_fx) + floor_div(longint'(s_in) - longint'(sumsq_fx),
                                                      longint'(n - 1));
        end
    endfunction

    // z >= thr/256 decided on squares: D^2 >= thr^2 * var.
    function automatic bit reaches(longint unsigned d2, longint unsigned thr,
                                   longint unsigned var_fx);
        longint unsigned t2;
        t2 = thr * thr;
        if (t2 == 0)
            return 1'b1;
        return (d2 / t2) >= var_fx;
    endfunction

    function automatic logic [2:0] grade_sample(longint unsigned s);
        longint unsigned msq, scaled, d2;
        longint var_fx, dev;
        msq = (mean_fx * mean_fx) >> 16;
        scaled = msq + msq / (seen_count - 1);
        var_fx = longint'(sumsq_fx) - longint'(scaled);
        dev = longint'(mean_fx) - longint'(s << 16);
        if (var_fx <= 0)
            return (dev > 0) ? LVL_CRITICAL : LVL_NOMINAL;
        if (dev < 0)
            return LVL_NOMINAL;
        d2 = longint'(dev) * longint'(dev);
        if (!reaches(d2, info_lvl, var_fx))
            return LVL_NOMINAL;
        if (!reaches(d2, warn_lvl, var_fx))
            return LVL_INFO;
        if (!reaches(d2, crit_lvl, var_fx))
            return LVL_WARNING;
        return LVL_CRITICAL;
    endfunction

    function automatic res_t predict_severity(logic [15:0] value, logic [31:0] stamp);
        res_t r;
        longint unsigned needed;
        needed = (need_count < 2) ? 2 : need_count;
        if (seen_count < needed) begin
            learn_sample(value);
            r.level = LVL_LEARN;
            r.rtime = '0;
        end else begin
            r.level = grade_sample(value);
            r.rtime = stamp;
            if (r.level <= LVL_INFO)
                learn_sample(value);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        $display("MISMATCH %s: expected %0d, got %0d (result %0d)", what, want, got,
                 result_count);
        error_count++;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (severity_queue.size() == 0) begin
                report_mismatch("unexpected result, level", 0, m_tdata[2:0]);
            end else begin
                want = severity_queue.pop_front();
                if (m_tdata[2:0] !== want.level)
                    report_mismatch("severity_level", want.level, m_tdata[2:0]);
                if (m_tdata[34:3] !== want.rtime)
                    report_mismatch("result_time", want.rtime, m_tdata[34:3]);
                if (want.level <= LVL_CRITICAL)
                    level_hits[want.level]++;
            end
            result_count++;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= 3000;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_sample(logic [15:0] value, logic [31:0] stamp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {stamp, value};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        severity_queue.push_back(predict_severity(value, stamp));
        sent_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (severity_queue.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] index, logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(index) << 2;
        pwdata <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        case (index)
            REG_REQUIRED: need_count = value;
            REG_INFO:     info_lvl = value;
            REG_WARNING:  warn_lvl = value;
            REG_CRITICAL: crit_lvl = value;
            default: ;
        endcase
    endtask

    task automatic set_levels(logic [15:0] req, logic [15:0] inf, logic [15:0] wrn,
                              logic [15:0] crt);
        wait_drained();
        write_register(REG_REQUIRED, req);
        write_register(REG_INFO, inf);
        write_register(REG_WARNING, wrn);
        write_register(REG_CRITICAL, crt);
    endtask

    // Short scoring window, flat samples for zero variance, then field extremes.
    task automatic test_directed();
        set_levels(16'd2, DEF_INFO, DEF_WARNING, DEF_CRITICAL);
        send_sample(16'd1000, 32'h0000_0001);
        send_sample(16'd1000, 32'hFFFF_FFFF);
        send_sample(16'd1000, 32'hA5A5_5A5A);  // zero variance, at mean
        send_sample(16'd999, 32'h5A5A_A5A5);   // zero variance, below mean
        send_sample(16'd1200, 32'h0000_0000);
        send_sample(16'd800, 32'h1234_5678);
        send_sample(16'd65535, 32'hFFFF_0000);
        send_sample(16'd0, 32'h0000_FFFF);
        send_sample(16'd1000, 32'h8000_0000);
        send_sample(16'd400, 32'h7FFF_FFFF);
        // Zero thresholds: a sample exactly at the mean meets them.
        set_levels(16'd2, 16'd0, 16'd0, 16'd0);
        send_sample(16'd900, 32'd11);
        send_sample(16'd65535, 32'd12);
        send_sample(16'd0, 32'd13);
        set_levels(16'd2, 16'd0, 16'd256, 16'd65535);
        send_sample(16'd100, 32'd14);
        send_sample(16'd9000, 32'd15);
        send_sample(16'd5000, 32'd16);
        // Largest window: everything learns again.
        set_levels(16'd65535, DEF_INFO, DEF_WARNING, DEF_CRITICAL);
        send_sample(16'd7, 32'd17);
        send_sample(16'd65535, 32'd18);
    endtask

    function automatic logic [15:0] pick_sample(int base, int spread);
        int r, v;
        r = $urandom_range(99);
        if (r < 70)
            v = base + $urandom_range(2 * spread) - spread;
        else if (r < 85)
            v = base - spread * $urandom_range(12, 1);
        else if (r < 93)
            v = $urandom_range(65535);
        else
            v = ($urandom_range(1) != 0) ? 65535 : 0;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    task automatic test_random_phase(int idle_pct, int stall_pct, int items, int base,
                                     int spread);
        wait_drained();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items)
            send_sample(pick_sample(base, spread), $urandom);
    endtask

    // Long receiver hold-off while samples keep coming, then a full drain and eight more samples.
    task automatic test_backpressure();
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests++;
        repeat (12)
            send_sample(pick_sample(30000, 500), $urandom);
        wait_drained();
        repeat (8)
            send_sample(pick_sample(30000, 500), $urandom);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        foreach (level_hits[i])
            level_hits[i] = 0;
        need_count = DEF_REQUIRED;
        info_lvl = DEF_INFO;
        warn_lvl = DEF_WARNING;
        crit_lvl = DEF_CRITICAL;
        mean_fx = 0;
        sumsq_fx = 0;
        seen_count = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        set_levels(16'd40, DEF_INFO, DEF_WARNING, DEF_CRITICAL);
        test_random_phase(0, 0, 320, 20000, 400);
        set_levels(16'd300, 16'd128, 16'd384, 16'd640);
        test_random_phase(76, 0, 320, 21000, 2000);
        test_backpressure();
        set_levels(16'd2, 16'd0, 16'd65535, 16'd65535);
        test_random_phase(0, 76, 100, 19000, 800);
        set_levels(16'd500, 16'd300, 16'd600, 16'd900);
        test_random_phase(0, 76, 220, 20500, 600);
        set_levels(16'd65535, 16'd65535, 16'd65535, 16'd65535);
        test_random_phase(31, 31, 40, 20000, 1000);
        set_levels(16'd1000, 16'd64, 16'd200, 16'd400);
        test_random_phase(31, 31, 360, 20000, 300);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d samples, checked %0d results in %0d cycles.", sent_count,
                 result_count, cycle_count);
        $display("Levels seen: learn %0d, nominal %0d, info %0d, warning %0d, critical %0d",
                 level_hits[0], level_hits[1], level_hits[2], level_hits[3], level_hits[4]);
        if (error_count == 0 && severity_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     severity_queue.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
